@@ design/mdrhm_pkg.sv @@
// ----------------------------------------------------------------------------
// Run-hour meter package
// Operation codes and item types shared by the run-hour meter modules.
// ----------------------------------------------------------------------------
package mdrhm_pkg;

    localparam int unsigned SEC_PER_MIN = 60;
    localparam int unsigned SEC_PER_HOUR = 3600;
    localparam logic [15:0] HOURS_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        OP_TICK      = 3'd0,
        OP_START     = 3'd1,
        OP_STOP      = 3'd2,
        OP_FOLD_ONE  = 3'd3,
        OP_FOLD_ALL  = 3'd4,
        OP_CLEAR_ALL = 3'd5,
        OP_QUERY     = 3'd6,
        OP_SPARE     = 3'd7
    } t_op;

    typedef struct packed {
        logic [2:0] op;
        logic [3:0] device_id;
    } t_cmd;

    typedef struct packed {
        logic        id_error;
        logic        running;
        logic [15:0] hours;
        logic [5:0]  minutes;
        logic [5:0]  seconds;
        logic [21:0] total_minutes;
        logic [31:0] pending_count;
    } t_result;

endpackage

@@ design/mdrhm_if.sv @@
// ----------------------------------------------------------------------------
// Run-hour meter channels
// Valid/ready channels for commands and results.
// ----------------------------------------------------------------------------
interface mdrhm_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] op;
    logic [3:0] device_id;
    modport source (output valid, output op, output device_id, input ready);
    modport sink (input valid, input op, input device_id, output ready);
endinterface

interface mdrhm_res_if;
    logic        valid;
    logic        ready;
    logic        id_error;
    logic        running;
    logic [15:0] hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
    logic [21:0] total_minutes;
    logic [31:0] pending_count;
    modport source (output valid, output id_error, output running, output hours,
                    output minutes, output seconds, output total_minutes,
                    output pending_count, input ready);
    modport sink (input valid, input id_error, input running, input hours,
                  input minutes, input seconds, input total_minutes,
                  input pending_count, output ready);
endinterface

@@ design/mdrhm_front.sv @@
// ----------------------------------------------------------------------------
// Run-hour meter command queue
// Accepts commands and holds them in a two-entry queue for the engine.
// ----------------------------------------------------------------------------
module mdrhm_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mdrhm_cmd_if.sink         i_cmd,
    output logic              o_valid,
    output mdrhm_pkg::t_cmd   o_cmd,
    input  logic              i_take
);
    import mdrhm_pkg::*;

    t_cmd       r_q [2];
    logic [1:0] r_cnt;
    logic       r_wp;
    logic       r_rp;
    logic       w_push;
    logic       w_pop;

    assign i_cmd.ready = (r_cnt != 2'd2);
    assign w_push = i_cmd.valid && i_cmd.ready;
    assign w_pop = i_take && (r_cnt != 2'd0);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp <= 1'b0;
            r_rp <= 1'b0;
        end else begin
            if (w_push) begin
                r_q[r_wp] <= '{op: i_cmd.op, device_id: i_cmd.device_id};
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

`ifndef ASSERT_OFF
    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2) else $error("queue count overflow");
    a_full_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !i_cmd.ready) else $error("ready while full");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> !o_valid) else $error("valid while empty");
`endif
endmodule

@@ design/mdrhm_engine.sv @@
// ----------------------------------------------------------------------------
// Run-hour meter engine
// Applies the command to the device accounts, visiting them in turn for fold all, and reports a result.
// ----------------------------------------------------------------------------
module mdrhm_engine #(
    parameter int unsigned DEVICES = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  mdrhm_pkg::t_cmd     i_cmd,
    output logic                o_take,
    mdrhm_res_if.source         o_res
);
    import mdrhm_pkg::*;

    localparam int unsigned DW = (DEVICES > 1) ? $clog2(DEVICES) : 1;

    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_REM, S_MS, S_ADD, S_WALK, S_MUL
    } t_state;

    t_state      r_state;
    t_cmd        r_cmd;
    logic [DW-1:0] r_dev;
    logic        r_run [DEVICES];
    logic [31:0] r_cnt [DEVICES];
    logic [15:0] r_h [DEVICES];
    logic [5:0]  r_m [DEVICES];
    logic [5:0]  r_s [DEVICES];
    logic [20:0] r_qh;
    logic [11:0] r_rem;
    logic [20:0] r_add_h;
    logic [5:0]  r_add_m;
    logic [5:0]  r_add_s;
    logic        r_fold;
    t_result     r_res;
    logic        r_out_v;

    logic        w_idv;
    logic [DW-1:0] w_id;
    logic [31:0] w_c;
    logic [63:0] w_qh;
    logic [20:0] w_hq;
    logic [11:0] w_rh;
    logic [27:0] w_qm;
    logic [5:0]  w_mq;
    logic [6:0]  w_s;
    logic [6:0]  w_m;
    logic [21:0] w_h;
    logic [6:0]  w_sn;
    logic [6:0]  w_mn;
    logic [21:0] w_hn;
    logic [21:0] w_tm;

    assign w_idv = ({28'd0, r_cmd.device_id} < 32'(DEVICES));
    assign w_id = r_cmd.device_id[DW-1:0];
    assign w_c = r_cnt[r_dev];
    // The reciprocal of 3600 is rounded down, so the estimate is at most one low.
    assign w_qh = ({32'd0, w_c} * 64'd1193046) >> 32;
    always_comb begin
        logic [31:0] rem;
        rem = w_c - (32'(r_qh) * 32'd3600);
        w_hq = r_qh;
        if (rem >= 32'd3600) begin
            rem = rem - 32'd3600;
            w_hq = w_hq + 21'd1;
        end
        w_rh = rem[11:0];
    end
    assign w_qm = ({16'd0, r_rem} * 28'd34953) >> 21;
    assign w_mq = w_qm[5:0];
    assign w_s = {1'b0, r_s[r_dev]} + {1'b0, r_add_s};
    assign w_sn = (w_s >= 7'd60) ? w_s - 7'd60 : w_s;
    assign w_m = {1'b0, r_m[r_dev]} + {1'b0, r_add_m} + {6'd0, (w_s >= 7'd60)};
    assign w_mn = (w_m >= 7'd60) ? w_m - 7'd60 : w_m;
    assign w_h = {6'd0, r_h[r_dev]} + {1'b0, r_add_h} + {21'd0, (w_m >= 7'd60)};
    assign w_hn = (w_h > {6'd0, HOURS_MAX}) ? {6'd0, HOURS_MAX} : w_h;
    assign w_tm = 22'(r_h[w_id] * 22'd60) + {16'd0, r_m[w_id]};

    assign o_take = (r_state == S_IDLE) && !r_out_v;
    assign o_res.valid = r_out_v;
    assign o_res.id_error = r_res.id_error;
    assign o_res.running = r_res.running;
    assign o_res.hours = r_res.hours;
    assign o_res.minutes = r_res.minutes;
    assign o_res.seconds = r_res.seconds;
    assign o_res.total_minutes = r_res.total_minutes;
    assign o_res.pending_count = r_res.pending_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_v <= 1'b0;
            r_dev <= '0;
            r_fold <= 1'b0;
            for (int i = 0; i < DEVICES; i++) begin
                r_run[i] <= 1'b0;
                r_cnt[i] <= '0;
                r_h[i] <= '0;
                r_m[i] <= '0;
                r_s[i] <= '0;
            end
        end else begin
            if (o_res.valid && o_res.ready) begin
                r_out_v <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid && o_take) begin
                        r_cmd <= i_cmd;
                        r_dev <= '0;
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    r_fold <= (r_cmd.op == OP_FOLD_ALL);
                    case (r_cmd.op)
                        OP_TICK: begin
                            for (int i = 0; i < DEVICES; i++) begin
                                if (r_run[i]) r_cnt[i] <= r_cnt[i] + 32'd1;
                            end
                            r_state <= S_MUL;
                        end
                        OP_START: begin
                            if (w_idv) r_run[w_id] <= 1'b1;
                            r_state <= S_MUL;
                        end
                        OP_STOP: begin
                            if (w_idv) begin
                                r_run[w_id] <= 1'b0;
                                r_h[w_id] <= '0;
                                r_m[w_id] <= '0;
                                r_s[w_id] <= '0;
                            end
                            r_state <= S_MUL;
                        end
                        OP_FOLD_ONE: begin
                            if (w_idv) begin
                                r_dev <= w_id;
                                r_state <= S_DIV;
                            end else begin
                                r_state <= S_MUL;
                            end
                        end
                        OP_FOLD_ALL: begin
                            r_dev <= '0;
                            r_state <= S_DIV;
                        end
                        OP_CLEAR_ALL: begin
                            for (int i = 0; i < DEVICES; i++) begin
                                r_cnt[i] <= '0;
                                r_h[i] <= '0;
                                r_m[i] <= '0;
                                r_s[i] <= '0;
                            end
                            r_state <= S_MUL;
                        end
                        default: r_state <= S_MUL;
                    endcase
                end
                S_DIV: begin
                    r_qh <= w_qh[20:0];
                    r_state <= S_REM;
                end
                S_REM: begin
                    r_add_h <= w_hq;
                    r_rem <= w_rh;
                    r_state <= S_MS;
                end
                S_MS: begin
                    r_add_m <= w_mq;
                    r_add_s <= 6'(r_rem - 12'(w_mq * 12'd60));
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_h[r_dev] <= w_hn[15:0];
                    r_m[r_dev] <= w_mn[5:0];
                    r_s[r_dev] <= w_sn[5:0];
                    r_cnt[r_dev] <= '0;
                    if (r_fold && (32'(r_dev) + 32'd1 < 32'(DEVICES))) begin
                        r_dev <= r_dev + DW'(1);
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (!r_out_v) begin
                        if (w_idv) begin
                            r_res <= '{id_error: 1'b0, running: r_run[w_id],
                                       hours: r_h[w_id], minutes: r_m[w_id],
                                       seconds: r_s[w_id], total_minutes: w_tm,
                                       pending_count: r_cnt[w_id]};
                        end else begin
                            r_res <= '{id_error: 1'b1, default: '0};
                        end
                        r_out_v <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_res.id_error) |-> (r_res.pending_count == 32'd0 && !r_res.running))
        else $error("error result not cleared");
    a_min_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> (r_res.minutes < 6'd60 && r_res.seconds < 6'd60))
        else $error("minutes or seconds out of range");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_take) else $error("take while busy");
`endif
endmodule

@@ design/multi_device_run_hour_meter_top.sv @@
// ----------------------------------------------------------------------------
// Multi-device run-hour meter
// Run-hour accounts for DEVICES devices with tick, start, stop, fold, clear and query.
// ----------------------------------------------------------------------------
// Usage: commands (op, device_id) enter on i_cmd; one result per command
// leaves on o_res with the addressed account after the command.
// A two-entry queue takes commands while the engine works on earlier ones.
// Tick, start, stop, clear and query go from the walk state straight to the
// result state; fold one passes through the divide, remainder, minutes and
// seconds, and add states in between, and fold all repeats those states for
// each device in turn, using the shared divide and carry unit.
// The engine takes the next item no sooner than the cycle after the result
// is accepted, so a command occupies the engine until its result is taken.
// The result register holds its item until o_res.ready; the engine does not
// begin the next item while a result waits, and the queue fills and drops
// i_cmd.ready once full.
// Reset (synchronous, i_rst_n low) clears every account and running flag
// and empties the queue; the block accepts items once i_rst_n is high again.
// ----------------------------------------------------------------------------
module multi_device_run_hour_meter_top #(
    parameter int unsigned DEVICES = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mdrhm_cmd_if.sink    i_cmd,
    mdrhm_res_if.source  o_res
);
    import mdrhm_pkg::*;

    logic w_valid;
    logic w_take;
    t_cmd w_cmd;

    mdrhm_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(i_cmd),
        .o_valid(w_valid), .o_cmd(w_cmd), .i_take(w_take)
    );

    mdrhm_engine #(.DEVICES(DEVICES)) u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_valid), .i_cmd(w_cmd),
        .o_take(w_take), .o_res(o_res)
    );
endmodule
